### sv/layer_blend_pixel_top_macros.svh
// Assertion shorthands for the layer blend pixel block.
// Both expect signals named clock and reset in the asserting module.
`ifndef LAYER_BLEND_PIXEL_TOP_MACROS_SVH
`define LAYER_BLEND_PIXEL_TOP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define LBP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LBP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/lbp_pkg.sv
package lbp_pkg;

   localparam int PIX_W      = 8;
   localparam int MODE_W     = 3;
   localparam int W_W        = 16;
   localparam int PROD_W     = 24;
   localparam int SUM_W      = 24;
   localparam int NUM_LANES  = 3;
   localparam int STAGES     = 5;

   // 255 * 255: full weight
   localparam logic [W_W-1:0] FULL_WEIGHT = 16'd65025;

   // floor(s / 65025) ~ (s * 66051) >> 32, low by at most one for s < 2^24
   localparam int RECIP_W     = 17;
   localparam int RECIP_SHIFT = 32;
   localparam int RECIP_PROD_W = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_FULL = 17'd66051;

   // floor(x / 3) = (x * 683) >> 11, exact for x <= 765
   localparam int GREY_SUM_W  = 10;
   localparam int GREY_PROD_W = 20;
   localparam int GREY_SHIFT  = 11;
   localparam logic [GREY_SUM_W-1:0] GREY_RECIP = 10'd683;

   localparam logic [MODE_W-1:0] MODE_NORMAL   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_ADD      = 3'd1;
   localparam logic [MODE_W-1:0] MODE_MULTIPLY = 3'd2;
   localparam logic [MODE_W-1:0] MODE_XOR      = 3'd3;
   localparam logic [MODE_W-1:0] MODE_DARKER   = 3'd4;
   localparam logic [MODE_W-1:0] MODE_BRIGHTER = 3'd5;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_BLEND_MODE    = 1'b0;
   localparam logic REG_LAYER_OPACITY = 1'b1;

   localparam logic [MODE_W-1:0] MODE_RESET    = MODE_NORMAL;
   localparam logic [PIX_W-1:0]  OPACITY_RESET = 8'd255;

   localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

   // per-stage load enables, bit 0 is the input stage
   typedef struct packed {
      logic [STAGES-1:0] load;
   } stage_en_type;

   // whole-pixel pick decided by the merge stage
   typedef struct packed {
      logic use_pick;
      logic take_layer;
   } pick_type;

endpackage

### sv/lbp_req_if.sv
interface lbp_req_if;
   import lbp_pkg::*;

   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] bg_blue;
   logic [PIX_W-1:0] bg_green;
   logic [PIX_W-1:0] bg_red;
   logic [PIX_W-1:0] layer_blue;
   logic [PIX_W-1:0] layer_green;
   logic [PIX_W-1:0] layer_red;
   logic [PIX_W-1:0] layer_pixel_alpha;

   modport source (
      output valid, bg_blue, bg_green, bg_red,
             layer_blue, layer_green, layer_red, layer_pixel_alpha,
      input  ready
   );

   modport sink (
      input  valid, bg_blue, bg_green, bg_red,
             layer_blue, layer_green, layer_red, layer_pixel_alpha,
      output ready
   );

endinterface

### sv/lbp_rsp_if.sv
interface lbp_rsp_if;
   import lbp_pkg::*;

   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] out_blue;
   logic [PIX_W-1:0] out_green;
   logic [PIX_W-1:0] out_red;

   modport source (
      output valid, out_blue, out_green, out_red,
      input  ready
   );

   modport sink (
      input  valid, out_blue, out_green, out_red,
      output ready
   );

endinterface

### sv/lbp_csr.sv
module lbp_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [lbp_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [lbp_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [lbp_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready,
   output logic [lbp_pkg::MODE_W-1:0]     blend_mode,
   output logic [lbp_pkg::PIX_W-1:0]      layer_opacity
);
   import lbp_pkg::*;

   logic              wr_en;
   logic              reg_idx;
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [PIX_W-1:0]  opacity_ff, opacity_in;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[2];

   always_comb begin
      mode_in    = mode_ff;
      opacity_in = opacity_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_BLEND_MODE:    mode_in    = pwdata[MODE_W-1:0];
            REG_LAYER_OPACITY: opacity_in = pwdata[PIX_W-1:0];
            default:           mode_in    = mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_RESET;
         opacity_ff <= OPACITY_RESET;
      end else begin
         mode_ff    <= mode_in;
         opacity_ff <= opacity_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_BLEND_MODE:    prdata = CSR_DATA_W'(mode_ff);
         REG_LAYER_OPACITY: prdata = CSR_DATA_W'(opacity_ff);
         default:           prdata = '0;
      endcase
   end

   assign blend_mode    = mode_ff;
   assign layer_opacity = opacity_ff;

endmodule

### sv/lbp_merge.sv
// Grey compare across all three lanes; decides darker/brighter picks.
module lbp_merge (
   input  logic                      clock,
   input  lbp_pkg::stage_en_type     en,
   input  logic [lbp_pkg::MODE_W-1:0] mode,
   input  logic [lbp_pkg::PIX_W-1:0] bg_red,
   input  logic [lbp_pkg::PIX_W-1:0] bg_green,
   input  logic [lbp_pkg::PIX_W-1:0] bg_blue,
   input  logic [lbp_pkg::PIX_W-1:0] ly_red,
   input  logic [lbp_pkg::PIX_W-1:0] ly_green,
   input  logic [lbp_pkg::PIX_W-1:0] ly_blue,
   output lbp_pkg::pick_type         pick
);
   import lbp_pkg::*;

   logic [GREY_SUM_W-1:0]  bg_sum, ly_sum;
   logic [GREY_PROD_W-1:0] bg_prod, ly_prod;
   logic [PIX_W-1:0]       grey_bg_ff, grey_bg_in;
   logic [PIX_W-1:0]       grey_ly_ff, grey_ly_in;

   assign bg_sum  = GREY_SUM_W'(bg_red) + GREY_SUM_W'(bg_green) + GREY_SUM_W'(bg_blue);
   assign ly_sum  = GREY_SUM_W'(ly_red) + GREY_SUM_W'(ly_green) + GREY_SUM_W'(ly_blue);
   assign bg_prod = GREY_PROD_W'(bg_sum) * GREY_PROD_W'(GREY_RECIP);
   assign ly_prod = GREY_PROD_W'(ly_sum) * GREY_PROD_W'(GREY_RECIP);
   assign grey_bg_in = bg_prod[GREY_SHIFT +: PIX_W];
   assign grey_ly_in = ly_prod[GREY_SHIFT +: PIX_W];

   always_ff @(posedge clock) begin
      if (en.load[0]) begin
         grey_bg_ff <= grey_bg_in;
         grey_ly_ff <= grey_ly_in;
      end
   end

   // tie keeps the background
   always_comb begin
      case (mode)
         MODE_DARKER: begin
            pick.use_pick   = 1'b1;
            pick.take_layer = grey_ly_ff < grey_bg_ff;
         end
         MODE_BRIGHTER: begin
            pick.use_pick   = 1'b1;
            pick.take_layer = grey_ly_ff > grey_bg_ff;
         end
         default: begin
            pick.use_pick   = 1'b0;
            pick.take_layer = 1'b0;
         end
      endcase
   end

endmodule

### sv/lbp_lane.sv
// One color channel: mode op, weighted mix, divide by full weight.
module lbp_lane (
   input  logic                       clock,
   input  lbp_pkg::stage_en_type      en,
   input  logic [lbp_pkg::MODE_W-1:0] mode,
   input  logic [lbp_pkg::PIX_W-1:0]  bg,
   input  logic [lbp_pkg::PIX_W-1:0]  ly,
   input  logic [lbp_pkg::W_W-1:0]    weight,
   input  lbp_pkg::pick_type          pick,
   output logic [lbp_pkg::PIX_W-1:0]  chan_out
);
   import lbp_pkg::*;

   logic [PIX_W:0]          add_sum;
   logic [2*PIX_W-1:0]      mul_prod;
   logic [PIX_W-1:0]        pre_in, pre1_ff, bg1_ff, ly1_ff;
   logic [PIX_W-1:0]        blend;
   logic [PROD_W-1:0]       pbg_in, pbg2_ff, pbl_in, pbl2_ff;
   logic [SUM_W-1:0]        sum3_ff, sum3_in, sum4_ff;
   logic [RECIP_PROD_W-1:0] recip_prod;
   logic [PIX_W-1:0]        q4_ff, q4_in;
   logic [SUM_W-1:0]        rem;
   logic [PIX_W-1:0]        out_ff, out_in;

   // stage 1: per-mode blend value
   assign add_sum  = (PIX_W+1)'(bg) + (PIX_W+1)'(ly);
   assign mul_prod = (2*PIX_W)'(bg) * (2*PIX_W)'(ly);

   always_comb begin
      case (mode)
         MODE_ADD:      pre_in = add_sum[PIX_W] ? PIX_MAX : add_sum[PIX_W-1:0];
         MODE_MULTIPLY: pre_in = mul_prod[PIX_W +: PIX_W];
         MODE_XOR:      pre_in = bg ^ ly;
         default:       pre_in = ly;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en.load[0]) begin
         pre1_ff <= pre_in;
         bg1_ff  <= bg;
         ly1_ff  <= ly;
      end
   end

   // stage 2: whole-pixel pick, weighted products
   assign blend  = pick.use_pick ? (pick.take_layer ? ly1_ff : bg1_ff) : pre1_ff;
   assign pbg_in = PROD_W'(bg1_ff) * PROD_W'(FULL_WEIGHT - weight);
   assign pbl_in = PROD_W'(blend) * PROD_W'(weight);

   always_ff @(posedge clock) begin
      if (en.load[1]) begin
         pbg2_ff <= pbg_in;
         pbl2_ff <= pbl_in;
      end
   end

   // stage 3: sum
   assign sum3_in = pbg2_ff + pbl2_ff;

   always_ff @(posedge clock) begin
      if (en.load[2]) begin
         sum3_ff <= sum3_in;
      end
   end

   // stage 4: reciprocal estimate, low by at most one
   assign recip_prod = RECIP_PROD_W'(sum3_ff) * RECIP_PROD_W'(RECIP_FULL);
   assign q4_in      = recip_prod[RECIP_SHIFT +: PIX_W];

   always_ff @(posedge clock) begin
      if (en.load[3]) begin
         q4_ff   <= q4_in;
         sum4_ff <= sum3_ff;
      end
   end

   // stage 5: remainder check and correction
   assign rem    = sum4_ff - SUM_W'(q4_ff) * SUM_W'(FULL_WEIGHT);
   assign out_in = q4_ff + PIX_W'(rem >= SUM_W'(FULL_WEIGHT));

   always_ff @(posedge clock) begin
      if (en.load[4]) begin
         out_ff <= out_in;
      end
   end

   assign chan_out = out_ff;

endmodule

### sv/layer_blend_pixel_top.sv
// An input transfer passes through the pipeline registers s1 to s5 before its result shows on rsp_chan.
// Throughput: one pixel per clock unless rsp_chan stalls; each pipeline stage
// holds only while the stage after it is full and stalled, so bubbles are squeezed out.
// Reset (synchronous, active high) empties the pipeline and sets blend_mode
// to normal and layer_opacity to 255; datapath registers are not reset.
`include "layer_blend_pixel_top_macros.svh"

module layer_blend_pixel_top (
   input  logic                           clock,
   input  logic                           reset,
   lbp_req_if.sink                        req_chan,
   lbp_rsp_if.source                      rsp_chan,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [lbp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [lbp_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [lbp_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import lbp_pkg::*;

   // Pipeline:
   //   s1  mode ops per lane (add/mul/xor), greys, weight = opacity * alpha
   //   s2  merge picks whole pixel for darker/brighter, two products per lane
   //   s3  product sum
   //   s4  reciprocal multiply for /65025
   //   s5  remainder correction, output register

   logic [MODE_W-1:0] blend_mode;
   logic [PIX_W-1:0]  layer_opacity;

   logic [STAGES-1:0] valid_ff, valid_in, load;
   stage_en_type      en;
   pick_type          pick;

   logic [W_W-1:0]    w1_ff, w1_in;

   logic [PIX_W-1:0]  lane_bg  [NUM_LANES];
   logic [PIX_W-1:0]  lane_ly  [NUM_LANES];
   logic [PIX_W-1:0]  lane_out [NUM_LANES];

   lbp_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (csr_psel),
      .penable       (csr_penable),
      .pwrite        (csr_pwrite),
      .paddr         (csr_paddr),
      .pwdata        (csr_pwdata),
      .prdata        (csr_prdata),
      .pready        (csr_pready),
      .blend_mode    (blend_mode),
      .layer_opacity (layer_opacity)
   );

   // Stage k loads when empty or when stage k+1 moves on; the output
   // stage moves on when its transfer completes.
   always_comb begin
      load[STAGES-1] = !valid_ff[STAGES-1] | rsp_chan.ready;
      for (int k = STAGES-2; k >= 0; k--) begin
         load[k] = !valid_ff[k] | load[k+1];
      end
   end

   always_comb begin
      valid_in[0] = load[0] ? req_chan.valid : valid_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         valid_in[k] = load[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign en.load        = load;
   assign req_chan.ready = load[0];
   assign rsp_chan.valid = valid_ff[STAGES-1];

   // Weight shared by all lanes
   assign w1_in = W_W'(layer_opacity) * W_W'(req_chan.layer_pixel_alpha);

   always_ff @(posedge clock) begin
      if (load[0]) begin
         w1_ff <= w1_in;
      end
   end

   // Lane 0 blue, 1 green, 2 red
   assign lane_bg[0] = req_chan.bg_blue;
   assign lane_bg[1] = req_chan.bg_green;
   assign lane_bg[2] = req_chan.bg_red;
   assign lane_ly[0] = req_chan.layer_blue;
   assign lane_ly[1] = req_chan.layer_green;
   assign lane_ly[2] = req_chan.layer_red;

   lbp_merge u_merge (
      .clock    (clock),
      .en       (en),
      .mode     (blend_mode),
      .bg_red   (req_chan.bg_red),
      .bg_green (req_chan.bg_green),
      .bg_blue  (req_chan.bg_blue),
      .ly_red   (req_chan.layer_red),
      .ly_green (req_chan.layer_green),
      .ly_blue  (req_chan.layer_blue),
      .pick     (pick)
   );

   for (genvar c = 0; c < NUM_LANES; c++) begin : g_lane
      lbp_lane u_lane (
         .clock    (clock),
         .en       (en),
         .mode     (blend_mode),
         .bg       (lane_bg[c]),
         .ly       (lane_ly[c]),
         .weight   (w1_ff),
         .pick     (pick),
         .chan_out (lane_out[c])
      );
   end

   assign rsp_chan.out_blue  = lane_out[0];
   assign rsp_chan.out_green = lane_out[1];
   assign rsp_chan.out_red   = lane_out[2];

   // An input transfer always lands in stage one.
   `LBP_ASSERT_NEXT(a_in_lands, req_chan.valid && req_chan.ready, valid_ff[0], "accepted pixel lost at stage one")
   // A finished pixel in stage four reaches the output when it loads.
   `LBP_ASSERT_NEXT(a_out_loads, valid_ff[STAGES-2] && load[STAGES-1], rsp_chan.valid, "pixel lost before output")
   // With nothing behind it, the output empties after its transfer.
   `LBP_ASSERT_NEXT(a_out_drains, rsp_chan.valid && rsp_chan.ready && !valid_ff[STAGES-2], !rsp_chan.valid, "result repeated on output")
   // Weight never exceeds full scale.
   `LBP_ASSERT_NOW(a_weight_range, valid_ff[0], w1_ff <= FULL_WEIGHT, "weight above full scale")

endmodule
